### design/cna_pkg.sv
// ----------------------------------------------------------------------------
// cna_pkg: shared types and constants for the complex number ALU
// Request payload structs, command and status codes, default sizes.
// ----------------------------------------------------------------------------
package cna_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    // command codes
    localparam logic [2:0] CMD_ADD  = 3'd0;
    localparam logic [2:0] CMD_SUB  = 3'd1;
    localparam logic [2:0] CMD_MUL  = 3'd2;
    localparam logic [2:0] CMD_DIV  = 3'd3;
    localparam logic [2:0] CMD_CONJ = 3'd4;
    localparam logic [2:0] CMD_MAG  = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] a_real;
        logic signed [31:0] a_imag;
        logic signed [31:0] b_real;
        logic signed [31:0] b_imag;
    } cna_req_t;

    typedef struct packed {
        logic signed [31:0] res_real;
        logic signed [31:0] res_imag;
        logic [1:0]         status;
    } cna_res_t;

endpackage

### design/complex_number_alu.sv
// ----------------------------------------------------------------------------
// complex_number_alu: pipelined complex arithmetic unit, signed fixed point
// Add, subtract, multiply, divide, conjugate and magnitude on Q16.16 parts.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_valid/s_ready with s_data (command and operands a, b).
//   Each request gives one result on m_valid/m_ready with m_data (real part,
//   imaginary part, status: ok, saturated, or divide by zero).
//   Throughput: one request per cycle when the receiver keeps m_ready high.
//   Pipeline length is set by the divider, which retires one quotient bit per
//   stage; every command takes the same path so results leave in request order.
//   A front pipeline forms the exact wide products, a two-entry queue parts it
//   from the back pipeline, which rounds, divides, takes roots and saturates.
//   When the receiver stalls the back pipeline holds, the queue fills, then
//   the front stops taking requests; nothing is lost.
//   Reset (aresetn low at a clock edge) empties all stages.
// ----------------------------------------------------------------------------
module complex_number_alu import cna_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  cna_req_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output cna_res_t m_data
);
    localparam int PW = 2 * WORD_BITS + 2;
    localparam int DW = 3 + 3 * PW;

    logic fv, fr, bv, br;
    logic [2:0] fc, bc;
    logic signed [PW-1:0] fx, fy, fd, bx, by, bd;

    cna_front #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .q_valid(fv), .q_ready(fr), .q_cmd(fc), .q_x(fx), .q_y(fy), .q_d(fd)
    );

    cna_queue #(.DW(DW)) u_queue (
        .aclk, .aresetn,
        .in_valid(fv), .in_ready(fr), .in_data({fc, fx, fy, fd}),
        .out_valid(bv), .out_ready(br), .out_data({bc, bx, by, bd})
    );

    cna_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .aclk, .aresetn,
        .q_valid(bv), .q_ready(br), .q_cmd(bc), .q_x(bx), .q_y(by), .q_d(bd),
        .m_valid, .m_ready, .m_data
    );
endmodule

### design/cna_front.sv
// ----------------------------------------------------------------------------
// cna_front: request intake and classification
// Truncates operands to the word size, decodes the command and forms the
// exact wide products and sums, then pushes the request into the queue.
// ----------------------------------------------------------------------------
module cna_front import cna_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  cna_req_t s_data,
    output logic     q_valid,
    input  logic     q_ready,
    output logic [2:0]              q_cmd,
    output logic signed [2*WORD_BITS+1:0] q_x,
    output logic signed [2*WORD_BITS+1:0] q_y,
    output logic signed [2*WORD_BITS+1:0] q_d
);
    localparam int PW = 2 * WORD_BITS + 2;

    // stage 1: operand capture
    logic              v1_reg;
    logic [2:0]        c1_reg;
    logic signed [WORD_BITS-1:0] ar_reg, ai_reg, br_reg, bi_reg;
    // stage 2: products
    logic              v2_reg;
    logic [2:0]        c2_reg;
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg;
    // stage 3: combined terms
    logic              v3_reg;
    logic [2:0]        c3_reg;
    logic signed [PW-1:0] x_reg, y_reg, d_reg;

    logic adv;
    assign adv = !v3_reg || q_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // operand fetch, product formation and combined terms
    always_ff @(posedge aclk) begin
        if (adv) begin
            c1_reg <= s_data.command;
            ar_reg <= s_data.a_real[WORD_BITS-1:0];
            ai_reg <= s_data.a_imag[WORD_BITS-1:0];
            br_reg <= s_data.b_real[WORD_BITS-1:0];
            bi_reg <= s_data.b_imag[WORD_BITS-1:0];
            c2_reg <= c1_reg;
            case (c1_reg)
                CMD_MAG: begin
                    p0_reg <= PW'(ar_reg * ar_reg);
                    p1_reg <= PW'(ai_reg * ai_reg);
                    p2_reg <= '0;
                    p3_reg <= '0;
                end
                CMD_ADD: begin
                    p0_reg <= PW'(ar_reg) + PW'(br_reg);
                    p1_reg <= PW'(ai_reg) + PW'(bi_reg);
                    p2_reg <= '0;
                    p3_reg <= '0;
                end
                CMD_SUB: begin
                    p0_reg <= PW'(ar_reg) - PW'(br_reg);
                    p1_reg <= PW'(ai_reg) - PW'(bi_reg);
                    p2_reg <= '0;
                    p3_reg <= '0;
                end
                CMD_CONJ: begin
                    p0_reg <= PW'(ar_reg);
                    p1_reg <= -PW'(ai_reg);
                    p2_reg <= '0;
                    p3_reg <= '0;
                end
                default: begin
                    // multiply and divide use the cross products
                    p0_reg <= PW'(ar_reg * br_reg);
                    p1_reg <= PW'(ai_reg * bi_reg);
                    p2_reg <= PW'(ai_reg * br_reg);
                    p3_reg <= PW'(ar_reg * bi_reg);
                end
            endcase
            // combined terms; the divide denominator |b|^2 is carried on q_d from den_reg
            c3_reg <= c2_reg;
            case (c2_reg)
                CMD_MUL: begin
                    x_reg <= p0_reg - p1_reg;
                    y_reg <= p3_reg + p2_reg;
                    d_reg <= '0;
                end
                CMD_DIV: begin
                    x_reg <= p0_reg + p1_reg;
                    y_reg <= p2_reg - p3_reg;
                    d_reg <= '0;
                end
                CMD_MAG: begin
                    x_reg <= p0_reg + p1_reg;
                    y_reg <= '0;
                    d_reg <= '0;
                end
                default: begin
                    x_reg <= p0_reg;
                    y_reg <= p1_reg;
                    d_reg <= '0;
                end
            endcase
        end
    end

    // the divide denominator needs b; compute it on its own path
    logic signed [PW-1:0] bb0_reg, bb1_reg, den_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            bb0_reg <= PW'(br_reg * br_reg);
            bb1_reg <= PW'(bi_reg * bi_reg);
            den_reg <= bb0_reg + bb1_reg;
        end
    end

    assign q_valid = v3_reg;
    assign q_cmd   = c3_reg;
    assign q_x     = x_reg;
    assign q_y     = y_reg;
    assign q_d     = (c3_reg == CMD_DIV) ? den_reg : d_reg;
endmodule

### design/cna_queue.sv
// ----------------------------------------------------------------------------
// cna_queue: short FIFO between front and back
// Two entries, so front and back stall independently.
// ----------------------------------------------------------------------------
module cna_queue #(
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [DW-1:0] in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [DW-1:0] out_data
);
    logic [DW-1:0] mem_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;
    logic          push, pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;
    assign out_data = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_data;
    end
endmodule

### design/cna_back.sv
// ----------------------------------------------------------------------------
// cna_back: execution of classified requests
// Rounding, saturation, a restoring divider and an integer square root; the
// divider and the root are unrolled into one pipeline stage per step.
// ----------------------------------------------------------------------------
module cna_back import cna_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     q_valid,
    output logic     q_ready,
    input  logic [2:0] q_cmd,
    input  logic signed [2*WORD_BITS+1:0] q_x,
    input  logic signed [2*WORD_BITS+1:0] q_y,
    input  logic signed [2*WORD_BITS+1:0] q_d,
    output logic     m_valid,
    input  logic     m_ready,
    output cna_res_t m_data
);
    localparam int PW = 2 * WORD_BITS + 2;
    localparam int MW = 2 * WORD_BITS;          // magnitude width of terms
    localparam int QW = WORD_BITS + 1;          // quotient bits kept
    localparam int NS = MW + FRAC_BITS;         // quotient bits before the round bit (divider takes NS+1 steps)
    localparam int RS = WORD_BITS;              // sqrt steps (result bits)
    localparam int NST = (NS > RS ? NS : RS) + 2;
    localparam logic signed [PW-1:0] WMAX = PW'((65'sd1 <<< (WORD_BITS-1)) - 1);
    localparam logic signed [PW-1:0] WMIN = -WMAX - PW'(1);
    localparam logic signed [PW-1:0] HALF = PW'(65'sd1 <<< (FRAC_BITS-1));

    typedef struct packed {
        logic              v;
        logic [2:0]        cmd;
        logic              nx, ny, z;
        logic [MW-1:0]     den;
        logic [MW+1:0]     rx, ry;    // partial remainders
        logic [NS:0]       nmx, nmy;  // numerators, shifted out MSB first
        logic [NS:0]       qx, qy;    // quotients
        logic [MW+1:0]     sr, sres;  // sqrt remainder and root
        logic signed [PW-1:0] x, y;
    } st_t;

    st_t pipe_reg [NST+1];
    st_t s0;
    logic adv;
    logic     ov_reg;

    // the whole pipeline holds while a result waits at the output
    assign adv = !ov_reg || m_ready;
    assign q_ready = adv;

    // entry: split signed divide numerators into sign and magnitude;
    // one extra low bit gives the rounding bit of the quotient
    always_comb begin
        s0 = '0;
        s0.v   = q_valid;
        s0.cmd = q_cmd;
        s0.x   = q_x;
        s0.y   = q_y;
        s0.den = q_d[MW-1:0];
        s0.z   = (q_d == '0);
        s0.nx  = q_x[PW-1];
        s0.ny  = q_y[PW-1];
        s0.nmx = (NS+1)'(q_x[PW-1] ? -q_x : q_x) << (FRAC_BITS + 1);
        s0.nmy = (NS+1)'(q_y[PW-1] ? -q_y : q_y) << (FRAC_BITS + 1);
        s0.sr  = (MW+2)'(q_x);
    end

    // one restoring step per stage for division (NS+1 bits incl. round)
    // and one root digit per stage for the square root
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= NST; i++) pipe_reg[i].v <= 1'b0;
        end else if (adv) begin
            pipe_reg[0] <= s0;
            for (int i = 1; i <= NST; i++) begin
                automatic st_t p = pipe_reg[i-1];
                automatic logic [MW+1:0] tx, ty, tr;
                automatic logic [MW+1:0] bitv;
                if (i <= NS + 1) begin
                    tx = {p.rx[MW:0], p.nmx[NS]};
                    ty = {p.ry[MW:0], p.nmy[NS]};
                    p.nmx = p.nmx << 1;
                    p.nmy = p.nmy << 1;
                    if (tx >= (MW+2)'(p.den)) begin
                        p.rx = tx - (MW+2)'(p.den); p.qx = {p.qx[NS-1:0], 1'b1};
                    end else begin
                        p.rx = tx; p.qx = {p.qx[NS-1:0], 1'b0};
                    end
                    if (ty >= (MW+2)'(p.den)) begin
                        p.ry = ty - (MW+2)'(p.den); p.qy = {p.qy[NS-1:0], 1'b1};
                    end else begin
                        p.ry = ty; p.qy = {p.qy[NS-1:0], 1'b0};
                    end
                end
                if (i <= RS) begin
                    bitv = (MW+2)'(1) << (2 * (RS - i));
                    tr = p.sres + bitv;
                    if (p.sr >= tr) begin
                        p.sr = p.sr - tr; p.sres = (p.sres >> 1) + bitv;
                    end else begin
                        p.sres = p.sres >> 1;
                    end
                end
                pipe_reg[i] <= p;
            end
        end
    end

    // final formatting of the last stage
    st_t f;
    logic signed [PW-1:0] rx_w, ry_w;
    logic [1:0] st_w;
    logic [NS:0] lx, ly, qxr, qyr;
    logic [MW+1:0] root;

    function automatic logic signed [PW-1:0] satv(input logic signed [PW-1:0] v,
                                                 inout logic [1:0] s);
        if (v > WMAX) begin s = ST_SAT; return WMAX; end
        if (v < WMIN) begin s = ST_SAT; return WMIN; end
        return v;
    endfunction

    always_comb begin
        f = pipe_reg[NST];
        st_w = ST_OK;
        rx_w = '0;
        ry_w = '0;
        // quotient with round bit: q = (raw + 1) >> 1 gives ties away from zero
        qxr = (f.qx >> 1) + (NS+1)'(f.qx[0]);
        qyr = (f.qy >> 1) + (NS+1)'(f.qy[0]);
        lx = f.nx ? (NS+1)'(WMAX) + 1'b1 : (NS+1)'(WMAX);
        ly = f.ny ? (NS+1)'(WMAX) + 1'b1 : (NS+1)'(WMAX);
        root = f.sres + (MW+2)'(f.sr > f.sres);
        case (f.cmd)
            CMD_ADD, CMD_SUB, CMD_CONJ: begin
                rx_w = satv(f.x, st_w);
                ry_w = satv(f.y, st_w);
            end
            CMD_MUL: begin
                rx_w = satv((f.x + HALF) >>> FRAC_BITS, st_w);
                ry_w = satv((f.y + HALF) >>> FRAC_BITS, st_w);
            end
            CMD_DIV: begin
                if (f.z) begin
                    st_w = ST_DIV0;
                end else begin
                    if (qxr > lx) begin st_w = ST_SAT; qxr = lx; end
                    if (qyr > ly) begin st_w = ST_SAT; qyr = ly; end
                    rx_w = f.nx ? -PW'(qxr) : PW'(qxr);
                    ry_w = f.ny ? -PW'(qyr) : PW'(qyr);
                end
            end
            CMD_MAG: begin
                if (PW'(root) > WMAX) begin st_w = ST_SAT; rx_w = WMAX; end
                else rx_w = PW'(root);
            end
            default: begin
            end
        endcase
    end

    // output register
    cna_res_t od_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) ov_reg <= 1'b0;
        else if (adv) ov_reg <= f.v;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            od_reg.res_real <= 32'(rx_w[WORD_BITS-1:0]);
            od_reg.res_imag <= 32'(ry_w[WORD_BITS-1:0]);
            od_reg.status   <= st_w;
        end
    end
    assign m_valid = ov_reg;
    assign m_data  = od_reg;
endmodule

### bench/complex_number_alu_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// complex_number_alu_test: self-checking bench for the complex number ALU
// Directed table of corner requests, then random traffic with random idling on
// both channels; every result is checked against its table row or the predictor.
// ----------------------------------------------------------------------------
module complex_number_alu_test;
    import cna_pkg::*;

    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;
    localparam int     FRAC = 16;
    localparam int     LATENCY = 2 * 32 + FRAC + 8;
    localparam int     NUM_RANDOM = 1430;
    localparam longint CYCLE_LIMIT = 400000;

    // directed table row: request, typed expectation where obvious
    typedef struct {
        cna_req_t req;
        bit       has_exp;
        cna_res_t exp;
    } dir_row_t;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    cna_req_t s_data;
    logic     m_valid;
    logic     m_ready;
    cna_res_t m_data;

    cna_res_t   pending_results[$];
    int         fail_count;
    longint     cycle_count;
    bit         sender_done;
    dir_row_t   dir_rows[$];

    complex_number_alu uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // timeout
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // saturate to the 32-bit word, flag overflow
    function automatic longint clip_word(input longint x, inout logic [1:0] st);
        if (x > WMAX) begin
            st = ST_SAT;
            return WMAX;
        end
        if (x < WMIN) begin
            st = ST_SAT;
            return WMIN;
        end
        return x;
    endfunction

    // round to nearest, ties up, drop fraction bits (arithmetic shift floors)
    function automatic longint round_frac(input longint x);
        return (x + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    endfunction

    // signed quotient mag * 2^FRAC / den, rounded half away from zero
    function automatic longint fixed_quotient(input longint num, input longint unsigned den,
                                              inout logic [1:0] st);
        logic                  neg;
        longint unsigned       mag;
        longint unsigned       lim;
        longint unsigned       q;
        longint unsigned       rem;
        neg = num < 0;
        mag = neg ? longint'(-num) : longint'(num);
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        q   = mag / den;
        rem = mag % den;
        if (q > (lim >> FRAC)) begin
            st = ST_SAT;
            q  = lim;
        end else begin
            for (int i = 0; i < FRAC; i++) begin
                rem = rem << 1;
                q   = q << 1;
                if (rem >= den) begin
                    rem = rem - den;
                    q   = q | 64'd1;
                end
            end
            rem = rem << 1;
            if (rem >= den) q++;
            if (q > lim) begin
                st = ST_SAT;
                q  = lim;
            end
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    // integer square root, bitwise
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // expected result of one complex request
    function automatic cna_res_t complex_result(input cna_req_t req);
        longint          ar, ai, br, bi, rr, ri;
        longint unsigned den, msq, f;
        logic [1:0]      st;
        cna_res_t        res;
        ar = req.a_real;
        ai = req.a_imag;
        br = req.b_real;
        bi = req.b_imag;
        rr = 0;
        ri = 0;
        st = ST_OK;
        case (req.command)
            CMD_ADD: begin
                rr = clip_word(ar + br, st);
                ri = clip_word(ai + bi, st);
            end
            CMD_SUB: begin
                rr = clip_word(ar - br, st);
                ri = clip_word(ai - bi, st);
            end
            CMD_MUL: begin
                rr = clip_word(round_frac(ar * br - ai * bi), st);
                ri = clip_word(round_frac(ar * bi + ai * br), st);
            end
            CMD_DIV: begin
                den = longint'(br * br) + longint'(bi * bi);
                if (den == 0) begin
                    st = ST_DIV0;
                end else begin
                    // numerators fit in 64 signed bits (|each| <= 2^63 only if
                    // both products are 2^62 with same sign; handled below)
                    rr = quotient_wide(ar * br, ai * bi, den, st);
                    ri = quotient_wide(ai * br, -(ar * bi), den, st);
                end
            end
            CMD_CONJ: begin
                rr = ar;
                ri = clip_word(-ai, st);
            end
            CMD_MAG: begin
                msq = longint'(ar * ar) + longint'(ai * ai);
                f   = int_sqrt(msq);
                if (msq - f * f > f) f++;
                if (f > 64'd2147483647) begin
                    f  = 64'd2147483647;
                    st = ST_SAT;
                end
                rr = longint'(f);
            end
            default: ;
        endcase
        res.res_real = rr[31:0];
        res.res_imag = ri[31:0];
        res.status   = st;
        return res;
    endfunction

    // p + q may reach 2^63: split sign and magnitude before dividing
    function automatic longint quotient_wide(input longint p, input longint q,
                                             input longint unsigned den,
                                             inout logic [1:0] st);
        logic            neg;
        longint unsigned mag;
        longint unsigned lim;
        longint unsigned quo;
        longint unsigned rem;
        if (p >= 0 && q >= 0) begin
            neg = 0;
            mag = longint'(p) + longint'(q);
        end else if (p < 0 && q < 0) begin
            neg = 1;
            mag = longint'(-p) + longint'(-q);
        end else begin
            neg = (p + q) < 0;
            mag = neg ? -(p + q) : (p + q);
        end
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        quo = mag / den;
        rem = mag % den;
        if (quo > (lim >> FRAC)) begin
            st  = ST_SAT;
            quo = lim;
        end else begin
            for (int i = 0; i < FRAC; i++) begin
                rem = rem << 1;
                quo = quo << 1;
                if (rem >= den) begin
                    rem = rem - den;
                    quo = quo | 64'd1;
                end
            end
            rem = rem << 1;
            if (rem >= den) quo++;
            if (quo > lim) begin
                st  = ST_SAT;
                quo = lim;
            end
        end
        return neg ? -longint'(quo) : longint'(quo);
    endfunction

    // random operand part: corners, small values, or full range
    function automatic logic [31:0] pick_part();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'd0;
            3, 4: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
            5: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic cna_req_t make_req(input logic [2:0] cmd, input logic [31:0] ar,
                                          input logic [31:0] ai, input logic [31:0] br,
                                          input logic [31:0] bi);
        cna_req_t r;
        r.command = cmd;
        r.a_real  = ar;
        r.a_imag  = ai;
        r.b_real  = br;
        r.b_imag  = bi;
        return r;
    endfunction

    function automatic cna_res_t make_res(input logic [31:0] rr, input logic [31:0] ri,
                                          input logic [1:0] st);
        cna_res_t r;
        r.res_real = rr;
        r.res_imag = ri;
        r.status   = st;
        return r;
    endfunction

    // one request through the handshake; queue its expectation on acceptance
    task automatic send_request(input cna_req_t req, input bit has_exp,
                                input cna_res_t exp);
        s_data  <= req;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(has_exp ? exp : complex_result(req));
    endtask

    task automatic idle_sender(input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // build the directed table
    task automatic load_table();
        dir_row_t row;
        logic [31:0] one;
        one = 32'h0001_0000;
        row.has_exp = 1;
        row.req = make_req(CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF);
        row.exp = make_res(32'h7FFF_FFFF, 32'h8000_0000, ST_SAT);
        dir_rows.push_back(row);
        row.req = make_req(CMD_ADD, one, 32'd0, one, 32'd0);
        row.exp = make_res(32'h0002_0000, 32'd0, ST_OK);
        dir_rows.push_back(row);
        row.req = make_req(CMD_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'hFFFF_FFFF);
        row.exp = make_res(32'h8000_0000, 32'h7FFF_FFFF, ST_SAT);
        dir_rows.push_back(row);
        row.req = make_req(CMD_SUB, 32'd5, 32'd7, 32'd5, 32'd7);
        row.exp = make_res(32'd0, 32'd0, ST_OK);
        dir_rows.push_back(row);
        row.req = make_req(CMD_DIV, one, one, 32'd0, 32'd0);
        row.exp = make_res(32'd0, 32'd0, ST_DIV0);
        dir_rows.push_back(row);
        row.req = make_req(CMD_DIV, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
        row.exp = make_res(32'd0, 32'd0, ST_DIV0);
        dir_rows.push_back(row);
        row.req = make_req(CMD_CONJ, 32'h1234_5678, 32'h8000_0000, 32'd9, 32'd9);
        row.exp = make_res(32'h1234_5678, 32'h7FFF_FFFF, ST_SAT);
        dir_rows.push_back(row);
        row.req = make_req(CMD_CONJ, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0);
        row.exp = make_res(32'h8000_0000, 32'h8000_0001, ST_OK);
        dir_rows.push_back(row);
        row.req = make_req(CMD_MAG, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
        row.exp = make_res(32'h7FFF_FFFF, 32'd0, ST_SAT);
        dir_rows.push_back(row);
        row.req = make_req(CMD_MAG, 32'd0, 32'd0, 32'd0, 32'd0);
        row.exp = make_res(32'd0, 32'd0, ST_OK);
        dir_rows.push_back(row);
        row.req = make_req(3'd6, one, one, one, one);
        row.exp = make_res(32'd0, 32'd0, ST_OK);
        dir_rows.push_back(row);
        row.req = make_req(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        row.exp = make_res(32'd0, 32'd0, ST_OK);
        dir_rows.push_back(row);
        // predictor-checked rows
        row.has_exp = 0;
        row.exp = make_res(32'd0, 32'd0, ST_OK);
        row.req = make_req(CMD_MUL, one, one, one, 32'hFFFF_0000);
        dir_rows.push_back(row);
        row.req = make_req(CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        dir_rows.push_back(row);
        row.req = make_req(CMD_MUL, 32'd1, 32'd0, 32'h0000_8000, 32'd0);
        dir_rows.push_back(row);
        row.req = make_req(CMD_MUL, 32'hFFFF_FFFF, 32'd0, 32'h0000_8000, 32'd0);
        dir_rows.push_back(row);
        row.req = make_req(CMD_DIV, 32'h0003_0000, 32'h0004_0000, one, 32'h0002_0000);
        dir_rows.push_back(row);
        row.req = make_req(CMD_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'd0);
        dir_rows.push_back(row);
        row.req = make_req(CMD_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        dir_rows.push_back(row);
        row.req = make_req(CMD_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        dir_rows.push_back(row);
        row.req = make_req(CMD_DIV, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'h0002_0000);
        dir_rows.push_back(row);
        row.req = make_req(CMD_MAG, 32'h0003_0000, 32'h0004_0000, 32'd0, 32'd0);
        dir_rows.push_back(row);
        row.req = make_req(CMD_MAG, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0);
        dir_rows.push_back(row);
    endtask

    // sender: reset, directed table, random requests
    initial begin
        cna_req_t req;
        cna_res_t none;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        sender_done = 0;
        fail_count  = 0;
        none        = '0;
        load_table();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            send_request(dir_rows[i].req, dir_rows[i].has_exp, dir_rows[i].exp);
            idle_sender($urandom_range(0, 1));
        end
        // drain fully before random traffic
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            req.command = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                       : 3'($urandom_range(0, 5));
            req.a_real = pick_part();
            req.a_imag = pick_part();
            req.b_real = pick_part();
            req.b_imag = ($urandom_range(0, 4) == 0) ? 32'd0 : pick_part();
            send_request(req, 0, none);
            if (n == NUM_RANDOM / 2) begin
                s_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge aclk);
            end else if (n < 200 || n > 1200) begin
                idle_sender(0);
            end else begin
                idle_sender(pick_gap());
            end
        end
        s_valid     <= 1'b0;
        sender_done = 1;
    end

    // receiver: random stalls, compare against oldest expectation
    initial begin
        cna_res_t exp;
        int       stall;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            stall = (cycle_count % 5000 < 800) ? 0 : pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result with no request outstanding: %h", m_data);
                    fail_count++;
                end else begin
                    exp = pending_results.pop_front();
                    if (m_data.res_real !== exp.res_real) begin
                        $error("res_real expected %h actual %h", exp.res_real,
                               m_data.res_real);
                        fail_count++;
                    end
                    if (m_data.res_imag !== exp.res_imag) begin
                        $error("res_imag expected %h actual %h", exp.res_imag,
                               m_data.res_imag);
                        fail_count++;
                    end
                    if (m_data.status !== exp.status) begin
                        $error("status expected %0d actual %0d", exp.status,
                               m_data.status);
                        fail_count++;
                    end
                end
            end
        end
    end

    // end of run
    initial begin
        wait (sender_done);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
